### hdl/pee_pkg.sv
// ----------------------------------------------------------------------------
// pee_pkg: shared types and constants
// Status codes, symbol codes and controller/datapath command structs.
// ----------------------------------------------------------------------------
package pee_pkg;

  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StUnder   = 3'd1;
  localparam logic [2:0] StOver    = 3'd2;
  localparam logic [2:0] StUnknown = 3'd3;
  localparam logic [2:0] StDivZero = 3'd4;

  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChPct   = 8'h25;
  localparam logic [7:0] ChPow   = 8'h24;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;

  typedef enum logic [2:0] {
    OpAdd = 3'd0, OpSub = 3'd1, OpMul = 3'd2, OpDiv = 3'd3, OpMod = 3'd4, OpPow = 3'd5
  } op_e;

  // Controller to datapath
  typedef struct packed {
    logic start;   // begin arithmetic on lhs/rhs
    op_e  op;
  } alu_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic        done;
    logic        divzero;
    logic [31:0] result;
  } alu_sts_t;

endpackage

### hdl/postfix_expression_evaluator.sv
// ----------------------------------------------------------------------------
// postfix_expression_evaluator: RPN evaluator on a bounded stack
// Channel   Dir  Payload
// s_axis    in   tdata[7:0] symbol, tuser end_marker
// m_axis    out  tdata[31:0] value, tuser[2:0] status
// Divide, modulo and power iterate in the ALU; a zero divisor or a negative
// exponent ends without iterating. The end marker reads the top of stack and
// then presents the result.
// Reset and the end marker clear the stack count and status; memory is not swept.
// A result waiting in the output register holds off every request until taken.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] symbol
  input  logic        s_axis_tuser,   // [0] end_marker
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] value
  output logic [2:0]  m_axis_tuser    // [2:0] status
);

  pee_pkg::alu_cmd_t cmd;
  pee_pkg::alu_sts_t sts;
  logic [31:0] lhs, rhs;

  pee_ctrl #(.Depth(STACK_DEPTH)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .symbol_i(s_axis_tdata), .end_i(s_axis_tuser),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .value_o(m_axis_tdata), .status_o(m_axis_tuser),
    .cmd_o(cmd), .lhs_o(lhs), .rhs_o(rhs), .sts_i(sts)
  );

  pee_alu u_alu (
    .clk_i, .rst_ni, .cmd_i(cmd), .lhs_i(lhs), .rhs_i(rhs), .sts_o(sts)
  );

endmodule

### hdl/pee_alu.sv
// ----------------------------------------------------------------------------
// pee_alu: multi-cycle arithmetic unit
// Add/sub and multiply in one step, restoring divide one bit per
// cycle, and square-and-multiply power one exponent bit per cycle.
// ----------------------------------------------------------------------------
module pee_alu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pee_pkg::alu_cmd_t cmd_i,
  input  logic [31:0]       lhs_i,
  input  logic [31:0]       rhs_i,
  output pee_pkg::alu_sts_t sts_o
);

  logic        busy_q, busy_d;
  pee_pkg::op_e op_q, op_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] acc_q, acc_d;     // quotient / power accumulator
  logic [31:0] rem_q, rem_d;     // remainder / squared base
  logic [31:0] div_q, div_d;     // divisor magnitude / exponent
  logic        nq_q, nq_d, nr_q, nr_d;
  logic        done_q, done_d, dz_q, dz_d;
  logic [31:0] res_q, res_d;
  logic [32:0] trial;
  logic [31:0] amag, bmag;

  assign amag = lhs_i[31] ? (~lhs_i + 32'd1) : lhs_i;
  assign bmag = rhs_i[31] ? (~rhs_i + 32'd1) : rhs_i;
  assign trial = {rem_q, acc_q[31]} - {1'b0, div_q};

  always_comb begin
    busy_d = busy_q; op_d = op_q; cnt_d = cnt_q; acc_d = acc_q; rem_d = rem_q;
    div_d = div_q; nq_d = nq_q; nr_d = nr_q; done_d = 1'b0; dz_d = dz_q; res_d = res_q;
    if (cmd_i.start) begin
      op_d = cmd_i.op; dz_d = 1'b0; cnt_d = 6'd0;
      case (cmd_i.op)
        pee_pkg::OpAdd: begin res_d = lhs_i + rhs_i; done_d = 1'b1; end
        pee_pkg::OpSub: begin res_d = lhs_i - rhs_i; done_d = 1'b1; end
        pee_pkg::OpMul: begin res_d = lhs_i * rhs_i; done_d = 1'b1; end
        pee_pkg::OpDiv, pee_pkg::OpMod: begin
          if (rhs_i == 32'd0) begin
            res_d = 32'd0; dz_d = 1'b1; done_d = 1'b1;
          end else begin
            busy_d = 1'b1; acc_d = amag; rem_d = 32'd0; div_d = bmag;
            nq_d = lhs_i[31] ^ rhs_i[31]; nr_d = lhs_i[31];
          end
        end
        pee_pkg::OpPow: begin
          if (rhs_i[31]) begin
            done_d = 1'b1;
            if (lhs_i == 32'd1) res_d = 32'd1;
            else if (lhs_i == 32'hFFFF_FFFF) res_d = rhs_i[0] ? 32'hFFFF_FFFF : 32'd1;
            else begin res_d = 32'd0; dz_d = (lhs_i == 32'd0); end
          end else begin
            busy_d = 1'b1; acc_d = 32'd1; rem_d = lhs_i; div_d = rhs_i;
          end
        end
        default: begin res_d = 32'd0; done_d = 1'b1; end
      endcase
    end else if (busy_q) begin
      if (op_q == pee_pkg::OpPow) begin
        // one exponent bit a cycle
        if (div_q[0]) acc_d = acc_q * rem_q;
        rem_d = rem_q * rem_q;
        div_d = {1'b0, div_q[31:1]};
        if (div_q[31:1] == 31'd0) begin
          busy_d = 1'b0; done_d = 1'b1;
          res_d = div_q[0] ? acc_q * rem_q : acc_q;
        end
      end else begin
        // restoring divide, one quotient bit a cycle
        if (!trial[32]) begin
          rem_d = trial[31:0]; acc_d = {acc_q[30:0], 1'b1};
        end else begin
          rem_d = {rem_q[30:0], acc_q[31]}; acc_d = {acc_q[30:0], 1'b0};
        end
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd31) begin
          busy_d = 1'b0; done_d = 1'b1;
          if (op_q == pee_pkg::OpDiv) res_d = nq_q ? (~acc_d + 32'd1) : acc_d;
          else                        res_d = nr_q ? (~rem_d + 32'd1) : rem_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0;
    end else begin
      busy_q <= busy_d; done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; cnt_q <= cnt_d; acc_q <= acc_d; rem_q <= rem_d; div_q <= div_d;
    nq_q <= nq_d; nr_q <= nr_d; dz_q <= dz_d; res_q <= res_d;
  end

  assign sts_o.done    = done_q;
  assign sts_o.divzero = dz_q;
  assign sts_o.result  = res_q;

  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !done_q) else $error("done while busy");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("done held");
  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && dz_q) |-> (res_q == 32'd0)) else $error("divzero nonzero");

endmodule

### hdl/pee_ctrl.sv
// ----------------------------------------------------------------------------
// pee_ctrl: sequencer with operand stack
// Decodes each symbol, pops operands from the stack memory, starts the ALU,
// pushes results and returns the final value on the end marker.
// ----------------------------------------------------------------------------
module pee_ctrl #(
  parameter int unsigned Depth = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        symbol_i,
  input  logic              end_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [31:0]       value_o,
  output logic [2:0]        status_o,
  output pee_pkg::alu_cmd_t cmd_o,
  output logic [31:0]       lhs_o,
  output logic [31:0]       rhs_o,
  input  pee_pkg::alu_sts_t sts_i
);

  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam logic [CW-1:0] Full = CW'(Depth);

  typedef enum logic [6:0] {
    SIdle = 7'b0000001, SRdRhs = 7'b0000010, SRdLhs = 7'b0000100,
    SLhsWt = 7'b0001000, SAlu = 7'b0010000, SEndRd = 7'b0100000,
    SOut = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [31:0] mem [Depth];
  logic [31:0] rd_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [2:0] err_q, err_d;
  logic halt_q, halt_d, unk_q, unk_d, rdok_q, rdok_d;
  pee_pkg::op_e op_q, op_d;
  logic [31:0] rhs_q, rhs_d, val_q, val_d;
  logic [2:0] st_q, st_d;
  logic ov_q, ov_d;
  logic we, re;
  logic [AW-1:0] waddr, raddr;
  logic [31:0] wdata;
  logic acc;
  logic [2:0] eflag;

  assign acc = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == SIdle) && !ov_q;

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; err_d = err_q; halt_d = halt_q; unk_d = unk_q;
    op_d = op_q; rhs_d = rhs_q; val_d = val_q; st_d = st_q; ov_d = ov_q; rdok_d = rdok_q;
    we = 1'b0; re = 1'b0; waddr = cnt_q[AW-1:0]; raddr = cnt_q[AW-1:0]; wdata = 32'd0;
    cmd_o.start = 1'b0; cmd_o.op = op_q; eflag = pee_pkg::StOk;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    case (state_q)
      SIdle: if (acc) begin
        if (end_i) begin
          if (cnt_q == '0) begin
            rdok_d = 1'b0; eflag = pee_pkg::StUnder;
          end else begin
            rdok_d = 1'b1; re = 1'b1; raddr = AW'(cnt_q - CW'(1));
          end
          state_d = SEndRd;
        end else if (halt_q || symbol_i == pee_pkg::ChSpace || symbol_i == pee_pkg::ChTab) begin
        end else if (symbol_i >= pee_pkg::ChZero && symbol_i <= pee_pkg::ChNine) begin
          if (cnt_q == Full) eflag = pee_pkg::StOver;
          else begin
            we = 1'b1; wdata = {24'd0, symbol_i - pee_pkg::ChZero}; cnt_d = cnt_q + CW'(1);
          end
        end else begin
          unk_d = 1'b0;
          case (symbol_i)
            pee_pkg::ChPlus:  op_d = pee_pkg::OpAdd;
            pee_pkg::ChMinus: op_d = pee_pkg::OpSub;
            pee_pkg::ChStar:  op_d = pee_pkg::OpMul;
            pee_pkg::ChSlash: op_d = pee_pkg::OpDiv;
            pee_pkg::ChPct:   op_d = pee_pkg::OpMod;
            pee_pkg::ChPow:   op_d = pee_pkg::OpPow;
            default:          unk_d = 1'b1;
          endcase
          if (cnt_q == '0) begin
            rdok_d = 1'b0; eflag = pee_pkg::StUnder;
          end else begin
            rdok_d = 1'b1; re = 1'b1; raddr = AW'(cnt_q - CW'(1)); cnt_d = cnt_q - CW'(1);
          end
          state_d = SRdRhs;
        end
      end
      SRdRhs: begin
        // rhs read data lands now; issue lhs pop
        rhs_d = rdok_q ? rd_q : 32'd0;
        if (cnt_q == '0) begin
          rdok_d = 1'b0; eflag = pee_pkg::StUnder;
        end else begin
          rdok_d = 1'b1; re = 1'b1; raddr = AW'(cnt_q - CW'(1)); cnt_d = cnt_q - CW'(1);
        end
        state_d = SRdLhs;
      end
      SRdLhs: begin
        if (unk_q) begin
          eflag = pee_pkg::StUnknown; halt_d = 1'b1; state_d = SIdle;
        end else begin
          cmd_o.start = 1'b1; state_d = SAlu;
        end
      end
      SAlu: if (sts_i.done) begin
        if (sts_i.divzero) eflag = pee_pkg::StDivZero;
        if (cnt_q == Full) eflag = sts_i.divzero ? pee_pkg::StDivZero : pee_pkg::StOver;
        else begin we = 1'b1; wdata = sts_i.result; cnt_d = cnt_q + CW'(1); end
        state_d = SIdle;
      end
      SEndRd: begin
        val_d = rdok_q ? rd_q : 32'd0; st_d = err_q; ov_d = 1'b1;
        cnt_d = '0; err_d = pee_pkg::StOk; halt_d = 1'b0; state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
    if (eflag != pee_pkg::StOk && err_q == pee_pkg::StOk) err_d = eflag;
    if (state_q == SEndRd) err_d = pee_pkg::StOk;
  end

  assign lhs_o = rdok_q ? rd_q : 32'd0;
  assign rhs_o = rhs_q;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rd_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; cnt_q <= '0; err_q <= pee_pkg::StOk; halt_q <= 1'b0; ov_q <= 1'b0;
      unk_q <= 1'b0; rdok_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; err_q <= err_d; halt_q <= halt_d; ov_q <= ov_d;
      unk_q <= unk_d; rdok_q <= rdok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; rhs_q <= rhs_d; val_q <= val_d; st_q <= st_d;
  end

  assign out_valid_o = ov_q;
  assign value_o = val_q;
  assign status_o = st_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= Full) else $error("stack count beyond depth");
  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SEndRd) |=> (cnt_q == '0 && err_q == pee_pkg::StOk && !halt_q))
    else $error("end did not clear");
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (state_q == SIdle)) else $error("ready outside idle");

endmodule

### sim/rpn_checker.sv
// ----------------------------------------------------------------------------
// rpn_checker: result predictor and scoreboard for the postfix evaluator
// Watches both stream channels, evaluates every accepted symbol on a private
// stack and compares each emitted value and status with the oldest prediction.
// ----------------------------------------------------------------------------
module rpn_checker #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  input  logic [2:0]  m_axis_tuser,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [31:0] value;
    logic [2:0]  status;
  } rpn_result_t;

  logic [31:0]  eval_stack [STACK_DEPTH];
  int unsigned  depth_q;
  logic [2:0]   status_q;
  bit           halted_q;
  rpn_result_t  result_q [$];
  int           fail_count;

  assign fail_count_o = fail_count;
  assign pending_o    = result_q.size();

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h, want %0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  function automatic void raise(input logic [2:0] code);
    if (status_q == pee_pkg::StOk) status_q = code;
  endfunction

  function automatic logic [31:0] pop_value();
    if (depth_q == 0) begin
      raise(pee_pkg::StUnder);
      return '0;
    end
    depth_q--;
    return eval_stack[depth_q];
  endfunction

  function automatic void push_value(input logic [31:0] v);
    if (depth_q >= STACK_DEPTH) begin
      raise(pee_pkg::StOver);
      return;
    end
    eval_stack[depth_q] = v;
    depth_q++;
  endfunction

  function automatic logic [31:0] raise_power(input logic [31:0] base,
                                              input logic [31:0] expo);
    logic [31:0] acc;
    logic [31:0] sq;
    acc = 1;
    sq  = base;
    if (expo[31]) begin
      if (base == 32'd1) return 32'd1;
      if (base == '1) return expo[0] ? '1 : 32'd1;
      if (base == '0) raise(pee_pkg::StDivZero);
      return '0;
    end
    while (expo != 0) begin
      if (expo[0]) acc = acc * sq;
      sq   = sq * sq;
      expo = expo >> 1;
    end
    return acc;
  endfunction

  function automatic void evaluate(input logic [7:0] sym, input logic endm);
    logic [31:0] lhs;
    logic [31:0] rhs;
    logic [31:0] res;
    rpn_result_t r;
    if (endm) begin
      r.value  = pop_value();
      r.status = status_q;
      result_q.push_back(r);
      depth_q  = 0;
      status_q = pee_pkg::StOk;
      halted_q = 0;
      return;
    end
    if (halted_q || sym == pee_pkg::ChSpace || sym == pee_pkg::ChTab) return;
    if (sym >= pee_pkg::ChZero && sym <= pee_pkg::ChNine) begin
      push_value(32'(sym - pee_pkg::ChZero));
      return;
    end
    rhs = pop_value();
    lhs = pop_value();
    case (sym)
      pee_pkg::ChPlus:  res = lhs + rhs;
      pee_pkg::ChMinus: res = lhs - rhs;
      pee_pkg::ChStar:  res = lhs * rhs;
      pee_pkg::ChSlash, pee_pkg::ChPct: begin
        if (rhs == 0) begin
          raise(pee_pkg::StDivZero);
          res = '0;
        end else if (lhs == 32'h8000_0000 && rhs == '1) begin
          res = (sym == pee_pkg::ChSlash) ? lhs : '0;
        end else begin
          res = (sym == pee_pkg::ChSlash) ? 32'($signed(lhs) / $signed(rhs))
                                          : 32'($signed(lhs) % $signed(rhs));
        end
      end
      pee_pkg::ChPow:   res = raise_power(lhs, rhs);
      default: begin
        raise(pee_pkg::StUnknown);
        halted_q = 1;
        return;
      end
    endcase
    push_value(res);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rpn_result_t want;
    if (!rst_ni) begin
      depth_q    = 0;
      status_q   = pee_pkg::StOk;
      halted_q   = 0;
      fail_count = 0;
      result_q.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) evaluate(s_axis_tdata, s_axis_tuser);
      if (m_axis_tvalid && m_axis_tready) begin
        if (result_q.size() == 0) begin
          report_mismatch("unexpected result", m_axis_tdata, '0);
        end else begin
          want = result_q.pop_front();
          if (m_axis_tdata !== want.value)
            report_mismatch("value", m_axis_tdata, want.value);
          if (m_axis_tuser !== want.status)
            report_mismatch("status", 32'(m_axis_tuser), 32'(want.status));
        end
      end
    end
  end

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the postfix evaluator
// Directed corner expressions, then random well-formed and broken expressions
// under three idling schemes; the checker instance predicts and compares.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned Depth      = 64;
  localparam int          CycleLimit = 1_000_000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  int          fail_count;
  int          pending;
  int          cycle_count;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          sent;

  postfix_expression_evaluator #(.STACK_DEPTH(Depth)) dut (.*);

  rpn_checker #(.STACK_DEPTH(Depth)) u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAIL postfix_expression_evaluator");
      $finish;
    end
  end

  // Receiver stalls at random.
  always @(posedge clk_i)
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

  // Present one request and hold it until accepted; valid stays up after
  // acceptance until the next request or an idle cycle replaces it.
  task automatic send_symbol(input logic [7:0] sym, input logic endm);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= sym;
    s_axis_tuser  <= endm;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent++;
  endtask

  task automatic send_text(input string text);
    foreach (text[i]) send_symbol(text[i], 0);
    send_symbol(8'($urandom_range(255)), 1);
  endtask

  function automatic logic [7:0] pick_operator();
    case ($urandom_range(5))
      0: return pee_pkg::ChPlus;
      1: return pee_pkg::ChMinus;
      2: return pee_pkg::ChStar;
      3: return pee_pkg::ChSlash;
      4: return pee_pkg::ChPct;
      default: return pee_pkg::ChPow;
    endcase
  endfunction

  // Random expression; mostly well formed, with single-digit operands.
  task automatic send_random_expression();
    int n;
    int live;
    logic [7:0] sym;
    n    = $urandom_range(1, 12);
    live = 0;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(19))
        0: sym = 8'($urandom_range(255));
        1: sym = ($urandom_range(1)) ? pee_pkg::ChSpace : pee_pkg::ChTab;
        2, 3: sym = pick_operator();
        default: sym = (live >= 2 && $urandom_range(2) == 0) ? pick_operator()
                       : 8'(pee_pkg::ChZero + $urandom_range(9));
      endcase
      if (sym >= pee_pkg::ChZero && sym <= pee_pkg::ChNine) live++;
      else if (sym inside {pee_pkg::ChPlus, pee_pkg::ChMinus, pee_pkg::ChStar,
                           pee_pkg::ChSlash, pee_pkg::ChPct, pee_pkg::ChPow}) live--;
      send_symbol(sym, 0);
    end
    send_symbol(8'($urandom_range(255)), 1);
  endtask

  // Drop valid and wait until every predicted result has come out.
  task automatic drain();
    s_axis_tvalid <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  initial begin
    string deep;
    cycle_count   = 0;
    sent          = 0;
    send_idle_pct = 15;
    recv_idle_pct = 77;
    rst_ni        = 0;
    s_axis_tvalid = 0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 0;
    m_axis_tready = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Corner expressions: every operator, divide by zero, negative powers,
    // underflow, unknown operator halting, skipped blanks.
    send_text("34+ 2\t*");
    send_text("09-7/");
    send_text("73%0/");
    send_text("95$");
    send_text("00$");
    send_text("205-$");
    send_text("114-$");
    send_text("0 19-$");
    send_text("+");
    send_text("");
    send_text("5#9+");
    send_text("\377\200");
    send_text("9999999$$$");
    deep = "";
    for (int i = 0; i < Depth + 2; i++) deep = {deep, "9"};
    send_text(deep);
    drain();

    while (sent < 600) send_random_expression();
    drain();
    send_idle_pct = 77;
    recv_idle_pct = 15;
    while (sent < 1200) send_random_expression();
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (sent < 1750) send_random_expression();
    drain();

    if (fail_count == 0) begin
      $display("PASS postfix_expression_evaluator");
    end else begin
      $display("FAIL postfix_expression_evaluator");
    end
    $finish;
  end

endmodule
